// File: rtl/wsd_pkg.sv
// wsd_pkg: types, codes and helpers for the websocket frame deframer.
// No dependencies; used by every other file of the block.
`default_nettype none

package wsd_pkg;

  // parse phase of the header/payload walker
  typedef enum logic [2:0] {
    PH_HDR1,
    PH_HDR2,
    PH_EXTLEN,
    PH_KEY,
    PH_PAYLOAD
  } phase_t;

  // result kinds
  localparam logic [1:0] KIND_HDR  = 2'd0;
  localparam logic [1:0] KIND_DATA = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  // opcodes
  localparam logic [3:0] OP_CONT   = 4'h0;
  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PONG   = 4'hA;

  // header byte fields
  localparam logic [6:0] LEN_EXT16 = 7'h7E;
  localparam logic [6:0] LEN_EXT64 = 7'h7F;

  localparam int unsigned LEN_W = 64;
  localparam int unsigned KEY_W = 32;

  typedef struct packed {
    logic [1:0]       result_kind;
    logic [3:0]       frame_opcode_out;
    logic             fin_out;
    logic             masked_out;
    logic [LEN_W-1:0] payload_length;
    logic [7:0]       data_byte;
    logic             is_text;
    logic             is_control;
    logic             last_of_frame;
    logic             last_of_message;
  } res_t;

  function automatic logic op_is_data(input logic [3:0] op);
    return (op == OP_CONT) || (op == OP_TEXT) || (op == OP_BINARY);
  endfunction

  function automatic logic op_is_ctl(input logic [3:0] op);
    return (op >= OP_CLOSE) && (op <= OP_PONG);
  endfunction

endpackage

`default_nettype wire

// File: rtl/wsd_if.sv
// wsd_in_if / wsd_out_if: valid/ready channels of the deframer.
// Depends on wsd_pkg for field widths.
`default_nettype none

interface wsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface wsd_out_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                result_kind;
  logic [3:0]                frame_opcode_out;
  logic                      fin_out;
  logic                      masked_out;
  logic [wsd_pkg::LEN_W-1:0] payload_length;
  logic [7:0]                data_byte;
  logic                      is_text;
  logic                      is_control;
  logic                      last_of_frame;
  logic                      last_of_message;

  modport source (
    output valid, output result_kind, output frame_opcode_out, output fin_out,
    output masked_out, output payload_length, output data_byte, output is_text,
    output is_control, output last_of_frame, output last_of_message,
    input ready
  );
  modport sink (
    input valid, input result_kind, input frame_opcode_out, input fin_out,
    input masked_out, input payload_length, input data_byte, input is_text,
    input is_control, input last_of_frame, input last_of_message,
    output ready
  );
endinterface

`default_nettype wire

// File: rtl/wsd_parser.sv
// wsd_parser: frame parse state and per-byte result logic.
// Depends on wsd_pkg.
`default_nettype none

module wsd_parser (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          take,
  input  wire logic [7:0]    byte_in,
  output logic               res_valid,
  output wsd_pkg::res_t      res
);

  wsd_pkg::phase_t                phase_r, phase_nxt;
  logic [2:0]                     cnt_r, cnt_nxt;
  logic                           ext_long_r, ext_long_nxt;
  logic [wsd_pkg::LEN_W-1:0]      len_r, len_nxt;
  logic [wsd_pkg::LEN_W-1:0]      rem_r, rem_nxt;
  logic [wsd_pkg::KEY_W-1:0]      key_r, key_nxt;
  logic [1:0]                     idx_r, idx_nxt;
  logic                           fin_r, fin_nxt;
  logic [3:0]                     op_r, op_nxt;
  logic                           masked_r, masked_nxt;
  logic                           fit_r, fit_nxt;

  logic                           hdr_done;
  logic                           data_f, ctl_f, lof;
  logic [7:0]                     key_byte;
  logic [wsd_pkg::LEN_W-1:0]      len_shift;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= wsd_pkg::PH_HDR1;
      cnt_r      <= '0;
      ext_long_r <= 1'b0;
      len_r      <= '0;
      rem_r      <= '0;
      key_r      <= '0;
      idx_r      <= '0;
      fin_r      <= 1'b0;
      op_r       <= '0;
      masked_r   <= 1'b0;
      fit_r      <= 1'b0;
    end else if (take) begin
      phase_r    <= phase_nxt;
      cnt_r      <= cnt_nxt;
      ext_long_r <= ext_long_nxt;
      len_r      <= len_nxt;
      rem_r      <= rem_nxt;
      key_r      <= key_nxt;
      idx_r      <= idx_nxt;
      fin_r      <= fin_nxt;
      op_r       <= op_nxt;
      masked_r   <= masked_nxt;
      fit_r      <= fit_nxt;
    end
  end

  assign data_f    = wsd_pkg::op_is_data(op_r);
  assign ctl_f     = wsd_pkg::op_is_ctl(op_r);
  assign key_byte  = key_r[8*(3 - idx_r) +: 8];
  assign len_shift = {len_r[wsd_pkg::LEN_W-9:0], byte_in};

  always_comb begin
    phase_nxt    = phase_r;
    cnt_nxt      = cnt_r;
    ext_long_nxt = ext_long_r;
    len_nxt      = len_r;
    rem_nxt      = rem_r;
    key_nxt      = key_r;
    idx_nxt      = idx_r;
    fin_nxt      = fin_r;
    op_nxt       = op_r;
    masked_nxt   = masked_r;
    fit_nxt      = fit_r;
    hdr_done     = 1'b0;
    lof          = 1'b0;
    res_valid    = 1'b0;
    res          = '0;

    unique case (phase_r)
      wsd_pkg::PH_HDR1: begin
        fin_nxt   = byte_in[7];
        op_nxt    = byte_in[3:0];
        phase_nxt = wsd_pkg::PH_HDR2;
      end
      wsd_pkg::PH_HDR2: begin
        masked_nxt = byte_in[7];
        cnt_nxt    = '0;
        if (byte_in[6:0] == wsd_pkg::LEN_EXT16 || byte_in[6:0] == wsd_pkg::LEN_EXT64) begin
          len_nxt      = '0;
          ext_long_nxt = (byte_in[6:0] == wsd_pkg::LEN_EXT64);
          phase_nxt    = wsd_pkg::PH_EXTLEN;
        end else begin
          len_nxt = {{(wsd_pkg::LEN_W-7){1'b0}}, byte_in[6:0]};
          if (byte_in[7]) phase_nxt = wsd_pkg::PH_KEY;
          else            hdr_done  = 1'b1;
        end
      end
      wsd_pkg::PH_EXTLEN: begin
        len_nxt = len_shift;
        cnt_nxt = cnt_r + 3'd1;
        if (ext_long_r ? (cnt_r == 3'd7) : (cnt_r == 3'd1)) begin
          cnt_nxt = '0;
          if (masked_r) phase_nxt = wsd_pkg::PH_KEY;
          else          hdr_done  = 1'b1;
        end
      end
      wsd_pkg::PH_KEY: begin
        key_nxt = {key_r[wsd_pkg::KEY_W-9:0], byte_in};
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == 3'd3) begin
          cnt_nxt  = '0;
          hdr_done = 1'b1;
        end
      end
      wsd_pkg::PH_PAYLOAD: begin
        lof     = (rem_r == {{(wsd_pkg::LEN_W-1){1'b0}}, 1'b1});
        rem_nxt = rem_r - {{(wsd_pkg::LEN_W-1){1'b0}}, 1'b1};
        idx_nxt = idx_r + 2'd1;
        res_valid              = 1'b1;
        res.result_kind        = wsd_pkg::KIND_DATA;
        res.data_byte          = byte_in ^ (masked_r ? key_byte : 8'h00);
        res.is_text            = data_f & fit_r;
        res.is_control         = ctl_f;
        res.last_of_frame      = lof;
        res.last_of_message    = lof & data_f & fin_r;
        if (lof) phase_nxt = wsd_pkg::PH_HDR1;
      end
      default: phase_nxt = wsd_pkg::PH_HDR1;
    endcase

    // header complete: close out with a header or error result
    if (hdr_done) begin
      res_valid = 1'b1;
      if (!data_f && !ctl_f) begin
        res.result_kind = wsd_pkg::KIND_ERR;
        phase_nxt       = wsd_pkg::PH_HDR1;
      end else begin
        if (op_r == wsd_pkg::OP_TEXT)        fit_nxt = 1'b1;
        else if (op_r == wsd_pkg::OP_BINARY) fit_nxt = 1'b0;
        lof                 = (len_nxt == '0);
        res.result_kind     = wsd_pkg::KIND_HDR;
        res.is_text         = data_f & fit_nxt;
        res.is_control      = ctl_f;
        res.last_of_frame   = lof;
        res.last_of_message = lof & data_f & fin_r;
        rem_nxt             = len_nxt;
        idx_nxt             = '0;
        phase_nxt           = lof ? wsd_pkg::PH_HDR1 : wsd_pkg::PH_PAYLOAD;
      end
    end

    // frame fields common to every result
    res.frame_opcode_out = op_r;
    res.fin_out          = fin_r;
    res.masked_out       = masked_nxt;
    res.payload_length   = len_nxt;
  end

endmodule

`default_nettype wire

// File: rtl/wsd_out_buf.sv
// wsd_out_buf: two-entry result buffer (output register plus skid slot).
// Depends on wsd_pkg.
`default_nettype none

module wsd_out_buf (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire wsd_pkg::res_t push_data,
  output logic               can_take,
  output logic               out_valid,
  input  wire logic          out_ready,
  output wsd_pkg::res_t      out_data
);

  logic          main_v_r, main_v_nxt;
  logic          skid_v_r, skid_v_nxt;
  wsd_pkg::res_t main_r, main_nxt;
  wsd_pkg::res_t skid_r, skid_nxt;
  logic          pop;

  assign pop       = main_v_r & out_ready;
  assign can_take  = ~skid_v_r;
  assign out_valid = main_v_r;
  assign out_data  = main_r;

  always_comb begin
    main_v_nxt = main_v_r;
    skid_v_nxt = skid_v_r;
    main_nxt   = main_r;
    skid_nxt   = skid_r;
    if (pop || !main_v_r) begin
      if (skid_v_r) begin
        main_nxt   = skid_r;
        main_v_nxt = 1'b1;
        skid_v_nxt = push;
        skid_nxt   = push_data;
      end else begin
        main_v_nxt = push;
        main_nxt   = push_data;
      end
    end else if (push) begin
      skid_v_nxt = 1'b1;
      skid_nxt   = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

endmodule

`default_nettype wire

// File: rtl/websocket_frame_deframer.sv
// websocket_frame_deframer: receive-side frame parser, top level.
// Depends on wsd_pkg, wsd_if, wsd_parser and wsd_out_buf.
//
// Takes the received byte stream one word (one byte) per clock while
// in_if.ready is high and walks the base frame header: FIN and opcode,
// MASK and the 7-bit length, an optional 16- or 64-bit big-endian extended
// length and an optional 4-byte masking key. When the header is complete
// it emits one header word (or an error word for a reserved opcode, after
// which the next byte starts a new header), then one word per payload
// byte, unmasked with key byte (i mod 4) and tagged with last-of-frame and
// last-of-message. Continuation frames report the text/binary type of the
// first fragment. Header bytes other than the last produce no output word.
// Throughput is one byte per clock with no gaps while in_if.ready is high.
// Results are registered in a two-entry output buffer (result register
// plus skid slot), so in_if.ready only drops after the sink has stalled
// long enough to fill both entries. Per-byte timing is set by the 64-bit
// remaining-count decrement and compare in the parser.
`default_nettype none

module websocket_frame_deframer (
  input  wire logic  clk,
  input  wire logic  rst_n,
  wsd_in_if.sink     in_if,
  wsd_out_if.source  out_if
);

  logic          take;
  logic          can_take;
  logic          res_valid;
  wsd_pkg::res_t res;
  wsd_pkg::res_t out_data;

  // a byte is taken whenever one is valid and the buffer has a free skid slot
  assign in_if.ready = can_take;
  assign take        = in_if.valid & can_take;

  wsd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .byte_in   (in_if.in_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  wsd_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (take & res_valid),
    .push_data (res),
    .can_take  (can_take),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .out_data  (out_data)
  );

  assign out_if.result_kind      = out_data.result_kind;
  assign out_if.frame_opcode_out = out_data.frame_opcode_out;
  assign out_if.fin_out          = out_data.fin_out;
  assign out_if.masked_out       = out_data.masked_out;
  assign out_if.payload_length   = out_data.payload_length;
  assign out_if.data_byte        = out_data.data_byte;
  assign out_if.is_text          = out_data.is_text;
  assign out_if.is_control       = out_data.is_control;
  assign out_if.last_of_frame    = out_data.last_of_frame;
  assign out_if.last_of_message  = out_data.last_of_message;

endmodule

`default_nettype wire

// File: rtl/wsd_checker.sv
// wsd_checker: port-level assertions for the deframer, bound to the top.
// Depends on wsd_pkg and websocket_frame_deframer.
`default_nettype none

module wsd_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] result_kind,
  input wire logic       is_text,
  input wire logic       is_control,
  input wire logic       last_of_frame,
  input wire logic       last_of_message
);

  // a stalled word stays offered
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output word dropped while stalled");

  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (result_kind == wsd_pkg::KIND_HDR || result_kind == wsd_pkg::KIND_DATA
                   || result_kind == wsd_pkg::KIND_ERR))
    else $error("bad result kind");

  a_lom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && last_of_message |-> last_of_frame && !is_control)
    else $error("last_of_message without end of data frame");

  a_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && result_kind == wsd_pkg::KIND_ERR |->
      !last_of_frame && !is_text && !is_control)
    else $error("error word carries frame flags");

  a_type: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(is_text && is_control))
    else $error("control frame marked as text");

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_if.valid),
  .out_ready       (out_if.ready),
  .result_kind     (out_if.result_kind),
  .is_text         (out_if.is_text),
  .is_control      (out_if.is_control),
  .last_of_frame   (out_if.last_of_frame),
  .last_of_message (out_if.last_of_message)
);

`default_nettype wire
